[design/assert_macros.svh]
// Assertion macros shared by the tone generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst, expr, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

[design/tgen_pkg.sv]
// Package with types and constants of the tone generator.
package tgen_pkg;

   localparam int unsigned DEF_SAMPLE_RATE_HZ     = 44100;
   localparam int unsigned DEF_SINE_TABLE_ENTRIES = 256;

   localparam int unsigned SHAPE_W  = 2;
   localparam int unsigned FREQ_W   = 14;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned PERIOD_W = 12;
   localparam int unsigned DVR_W    = FREQ_W;

   localparam int unsigned FREQ_MIN   = 20;
   localparam int unsigned FREQ_MAX   = 12500;
   localparam int unsigned FREQ_RESET = 440;
   localparam int unsigned PERIOD_MAX = 4095;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [SHAPE_W-1:0] {
      SHAPE_SINE,
      SHAPE_SQUARE,
      SHAPE_TRIANGLE,
      SHAPE_SAWTOOTH
   } shape_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE_DIV,
      ST_FORM,
      ST_PERIOD_DIV,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic accept;
      logic form;
      logic period_commit;
      logic deliver;
   } tgen_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic wrap;
      logic out_free;
   } tgen_status_type;

endpackage

[design/tgen_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
module tgen_divider #(
   parameter int unsigned DIV_W = 28,
   parameter int unsigned DVR_W = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVR_W-1:0] divisor,
   output logic             busy,
   output logic [DIV_W-1:0] quotient
);
   localparam int unsigned CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVR_W-1:0] rem_ff, rem_in;
   logic [DVR_W-1:0] dvr_ff, dvr_in;
   logic [DVR_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = trial >= {1'b0, dvr_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvr_in  = dvr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? DVR_W'(trial - {1'b0, dvr_ff}) : trial[DVR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvr_ff <= dvr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[design/tgen_datapath.sv]
// Datapath of the tone generator: phase state, divider, sine table and output word.
`include "assert_macros.svh"
module tgen_datapath #(
   parameter int unsigned SAMPLE_RATE_HZ     = tgen_pkg::DEF_SAMPLE_RATE_HZ,
   parameter int unsigned SINE_TABLE_ENTRIES = tgen_pkg::DEF_SINE_TABLE_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tgen_pkg::tgen_cmd_type           cmd,
   output tgen_pkg::tgen_status_type        status,
   input  logic [tgen_pkg::SHAPE_W-1:0]     req_wave_shape,
   input  logic [tgen_pkg::FREQ_W-1:0]      req_new_frequency,
   input  logic                             req_block_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [tgen_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                             rsp_block_end_out
);
   import tgen_pkg::*;

   localparam int unsigned N        = SINE_TABLE_ENTRIES;
   localparam int unsigned PQ_W     = $clog2(4 * N);
   localparam int unsigned IDX_W    = $clog2(N + 1);
   localparam int unsigned RAMP_W   = PERIOD_W + SAMPLE_W;
   localparam int unsigned SINE_W   = PERIOD_W + PQ_W;
   localparam int unsigned SR_W     = $clog2(SAMPLE_RATE_HZ + 1);
   localparam int unsigned DIV_A_W  = (RAMP_W > SINE_W) ? RAMP_W : SINE_W;
   localparam int unsigned DIV_W    = (DIV_A_W > SR_W) ? DIV_A_W : SR_W;
   localparam int unsigned PER_RAW  = SAMPLE_RATE_HZ / FREQ_RESET;
   localparam int unsigned PER_INIT = (PER_RAW > PERIOD_MAX) ? PERIOD_MAX :
                                      ((PER_RAW < 1) ? 1 : PER_RAW);
   localparam logic [PERIOD_W-1:0] PER_RESET = PERIOD_W'(PER_INIT);
   localparam logic [PQ_W-1:0]  Q1 = PQ_W'(N);
   localparam logic [PQ_W-1:0]  Q2 = PQ_W'(2 * N);
   localparam logic [PQ_W-1:0]  Q3 = PQ_W'(3 * N);
   localparam logic [IDX_W-1:0] IDX_N = IDX_W'(N);
   localparam logic [DIV_W-1:0] FOUR_N = DIV_W'(4 * N);

   typedef logic [SAMPLE_W-2:0] rom_type [0:N];

   function automatic logic [SAMPLE_W-2:0] sine_entry(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [65:0] sum;
      logic signed [65:0] v;
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_ENTRIES;
      x2   = (x * x) >> 30;
      sum  = 66'(x);
      term = ((x * x2) >> 30) / 6;
      sum  = sum - 66'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + 66'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - 66'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + 66'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - 66'(term);
      if (sum < 0) begin
         sum = '0;
      end
      v = (sum + 66'sd16384) >>> 15;
      if (v > 66'sd32767) begin
         v = 66'sd32767;
      end
      return v[SAMPLE_W-2:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type t;
      for (int unsigned k = 0; k <= N; k++) begin
         t[k] = sine_entry(k);
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [PERIOD_W-1:0]       pos_ff, pos_in;
   logic [PERIOD_W-1:0]       per_ff, per_in;
   shape_type                 shape_ff;
   logic [FREQ_W-1:0]         freq_ff;
   logic                      blk_ff;
   logic                      lo_ff;
   logic                      half0_ff;
   logic [SAMPLE_W-2:0]       rom_data_ff;
   logic signed [SAMPLE_W-1:0] result_ff, result_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                      rsp_block_end_out_ff;

   logic [PERIOD_W-2:0]       half;
   logic                      lo;
   logic [PERIOD_W-1:0]       ramp_pos;
   logic [PERIOD_W:0]         pos_inc;
   logic                      wrap;
   logic                      div_start;
   logic [DIV_W-1:0]          div_dividend;
   logic [DVR_W-1:0]          div_divisor;
   logic                      div_busy;
   logic [DIV_W-1:0]          quo;
   logic [FREQ_W-1:0]         freq_clamped;
   logic [PQ_W-1:0]           p;
   logic [PQ_W-1:0]           k;
   logic                      quad_odd;
   logic                      quad_neg;
   logic [IDX_W-1:0]          rom_idx;
   logic [SAMPLE_W:0]         q17;
   logic [PERIOD_W-1:0]       per_new;

   tgen_divider #(
      .DIV_W(DIV_W),
      .DVR_W(DVR_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .busy    (div_busy),
      .quotient(quo)
   );

   always_comb begin
      half     = per_ff[PERIOD_W-1:1];
      lo       = pos_ff < {1'b0, half};
      ramp_pos = lo ? pos_ff : (pos_ff - {1'b0, half});
      pos_inc  = {1'b0, pos_ff} + 1'b1;
      wrap     = pos_inc >= {1'b0, per_ff};

      freq_clamped = freq_ff;
      if (freq_ff < FREQ_W'(FREQ_MIN)) begin
         freq_clamped = FREQ_W'(FREQ_MIN);
      end else if (freq_ff > FREQ_W'(FREQ_MAX)) begin
         freq_clamped = FREQ_W'(FREQ_MAX);
      end

      div_start    = cmd.accept || (cmd.form && wrap);
      div_dividend = DIV_W'(SAMPLE_RATE_HZ);
      div_divisor  = freq_clamped;
      if (cmd.accept) begin
         case (shape_type'(req_wave_shape))
            SHAPE_SINE: begin
               div_dividend = DIV_W'(pos_ff) * FOUR_N;
               div_divisor  = DVR_W'(per_ff);
            end
            SHAPE_TRIANGLE: begin
               div_dividend = DIV_W'(ramp_pos) << SAMPLE_W;
               div_divisor  = DVR_W'(half);
            end
            default: begin
               div_dividend = DIV_W'(pos_ff) << SAMPLE_W;
               div_divisor  = DVR_W'(per_ff);
            end
         endcase
      end

      p = quo[PQ_W-1:0];
      if (p >= Q3) begin
         k        = p - Q3;
         quad_odd = 1'b1;
         quad_neg = 1'b1;
      end else if (p >= Q2) begin
         k        = p - Q2;
         quad_odd = 1'b0;
         quad_neg = 1'b1;
      end else if (p >= Q1) begin
         k        = p - Q1;
         quad_odd = 1'b1;
         quad_neg = 1'b0;
      end else begin
         k        = p;
         quad_odd = 1'b0;
         quad_neg = 1'b0;
      end
      rom_idx = quad_odd ? (IDX_N - IDX_W'(k)) : IDX_W'(k);

      q17 = quo[SAMPLE_W:0];
      case (shape_ff)
         SHAPE_SINE: begin
            result_in = quad_neg ? SAMPLE_W'(-$signed({1'b0, rom_data_ff}))
                                 : $signed({1'b0, rom_data_ff});
         end
         SHAPE_SQUARE: begin
            result_in = lo_ff ? 16'sh7FFF : 16'sh8000;
         end
         SHAPE_TRIANGLE: begin
            if (half0_ff || (!lo_ff && (q17 == '0))) begin
               result_in = 16'sh7FFF;
            end else if (lo_ff) begin
               result_in = $signed({~q17[SAMPLE_W-1], q17[SAMPLE_W-2:0]});
            end else begin
               result_in = $signed(SAMPLE_W'(17'h08000 - q17));
            end
         end
         default: begin
            result_in = $signed({~q17[SAMPLE_W-1], q17[SAMPLE_W-2:0]});
         end
      endcase

      if (quo > DIV_W'(PERIOD_MAX)) begin
         per_new = PERIOD_W'(PERIOD_MAX);
      end else if (quo == '0) begin
         per_new = PERIOD_W'(1);
      end else begin
         per_new = quo[PERIOD_W-1:0];
      end

      pos_in = pos_ff;
      if (cmd.form) begin
         pos_in = wrap ? '0 : pos_inc[PERIOD_W-1:0];
      end
      per_in = cmd.period_commit ? per_new : per_ff;

      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      status.div_busy = div_busy;
      status.wrap     = wrap;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         per_ff       <= PER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         per_ff       <= per_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.accept) begin
         shape_ff <= shape_type'(req_wave_shape);
         freq_ff  <= req_new_frequency;
         blk_ff   <= req_block_end;
         lo_ff    <= lo;
         half0_ff <= (half == '0);
      end
      rom_data_ff <= SINE_ROM[rom_idx];
      if (cmd.form) begin
         result_ff <= result_in;
      end
      if (cmd.deliver) begin
         rsp_sample_ff        <= result_ff;
         rsp_block_end_out_ff <= blk_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = rsp_sample_ff;
   assign rsp_block_end_out = rsp_block_end_out_ff;

   `ASSERT_ALWAYS(a_pos_in_period, clock, reset, pos_ff < per_ff, "Position left the period.")
   `ASSERT_ALWAYS(a_period_nonzero, clock, reset, per_ff != '0, "Period length is zero.")
   `ASSERT_NEXT(a_accept_starts_div, clock, reset, cmd.accept, div_busy, "Divider did not start.")

endmodule

[design/tgen_ctrl.sv]
// Controller state machine that sequences one sample word through the datapath.
module tgen_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tgen_pkg::tgen_status_type status,
   output tgen_pkg::tgen_cmd_type    cmd
);
   import tgen_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      cmd.accept        = 1'b0;
      cmd.form          = 1'b0;
      cmd.period_commit = 1'b0;
      cmd.deliver       = 1'b0;
      req_stall         = reset || (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = ST_SAMPLE_DIV;
            end
         end
         ST_SAMPLE_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_FORM;
            end
         end
         ST_FORM: begin
            cmd.form = 1'b1;
            state_in = status.wrap ? ST_PERIOD_DIV : ST_DELIVER;
         end
         ST_PERIOD_DIV: begin
            if (!status.div_busy) begin
               cmd.period_commit = 1'b1;
               state_in          = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/multi_waveform_tone_generator_unit.sv]
// Top level of the multi-waveform tone generator.
// A word is accepted, divided for its sample, formed, and loaded into the output register
// once the output is free; the divider is 28 bits wide by default, and a period wrap adds
// a division for the new period. The next word can be accepted in the cycle after the load.
// Throughput is set by the single bit-serial divider shared by sample and period math.
// Synchronous reset clears position to zero and period to the 440 Hz length.
module multi_waveform_tone_generator_unit #(
   parameter int unsigned SAMPLE_RATE_HZ     = tgen_pkg::DEF_SAMPLE_RATE_HZ,
   parameter int unsigned SINE_TABLE_ENTRIES = tgen_pkg::DEF_SINE_TABLE_ENTRIES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tgen_pkg::SHAPE_W-1:0]         req_wave_shape,
   input  logic [tgen_pkg::FREQ_W-1:0]          req_new_frequency,
   input  logic                                 req_block_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tgen_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                 rsp_block_end_out
);
   import tgen_pkg::*;

   tgen_cmd_type    cmd;
   tgen_status_type status;

   tgen_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   tgen_datapath #(
      .SAMPLE_RATE_HZ    (SAMPLE_RATE_HZ),
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_wave_shape   (req_wave_shape),
      .req_new_frequency(req_new_frequency),
      .req_block_end    (req_block_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_block_end_out(rsp_block_end_out)
   );

endmodule

[tb/tb_multi_waveform_tone_generator_unit.sv]
// Self-checking testbench for the multi-waveform tone generator with a scoreboard class.
module tb_multi_waveform_tone_generator_unit;
   import tgen_pkg::*;

   localparam int unsigned RATE_HZ      = DEF_SAMPLE_RATE_HZ;
   localparam int unsigned TABLE_N      = DEF_SINE_TABLE_ENTRIES;
   localparam int unsigned RANDOM_WORDS = 1430;
   localparam int unsigned CALM_TAIL    = 200;
   localparam int unsigned DEEP_AT      = 1200;
   localparam int unsigned SETTLE_CYC   = 80;

   typedef enum int unsigned {
      BAND_HIGH,
      BAND_ABOVE,
      BAND_MID,
      BAND_NOISE,
      BAND_SLOW,
      BAND_DEEP
   } band_type;

   class tone_scoreboard;
      int                   quarter_wave [0:TABLE_N];
      int unsigned          position;
      int unsigned          period_len;
      logic signed [15:0]   pending_samples [$];
      logic                 pending_block_ends [$];
      int unsigned          errors;
      int unsigned          words_seen;
      int unsigned          samples_checked;
      int unsigned          wraps;
      int unsigned          shape_seen [4];

      function new();
         for (int k = 0; k <= TABLE_N; k++) quarter_wave[k] = table_entry(k);
         position   = 0;
         period_len = period_of(FREQ_RESET);
      endfunction

      function int table_entry(int unsigned k);
         longint unsigned x, x2, term;
         longint          sum, v;
         x    = HALF_PI_Q30 * longint'(k) / longint'(TABLE_N);
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int unsigned i = 1; i <= 5; i++) begin
            term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
            if (i[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) sum = 0;
         v = (sum + 16384) / 32768;
         if (v > 32767) v = 32767;
         return int'(v);
      endfunction

      function int unsigned period_of(int unsigned freq);
         int unsigned f, p;
         f = freq;
         if (f < FREQ_MIN) f = FREQ_MIN;
         if (f > FREQ_MAX) f = FREQ_MAX;
         p = RATE_HZ / f;
         if (p > PERIOD_MAX) p = PERIOD_MAX;
         if (p < 1) p = 1;
         return p;
      endfunction

      function int predict_sample(shape_type shape, int unsigned pos, int unsigned per);
         int unsigned half, p, q, k;
         int          v;
         half = per / 2;
         case (shape)
            SHAPE_SINE: begin
               p = (pos * 4 * TABLE_N) / per;
               q = (p / TABLE_N) & 3;
               k = p % TABLE_N;
               case (q)
                  0: v = quarter_wave[k];
                  1: v = quarter_wave[TABLE_N - k];
                  2: v = -quarter_wave[k];
                  default: v = -quarter_wave[TABLE_N - k];
               endcase
            end
            SHAPE_SQUARE: begin
               v = (pos < half) ? 32767 : -32768;
            end
            SHAPE_TRIANGLE: begin
               if (half == 0) begin
                  v = 32767;
               end else if (pos < half) begin
                  v = -32768 + int'((65536 * pos) / half);
               end else begin
                  v = 32768 - int'((65536 * (pos - half)) / half);
                  if (v > 32767) v = 32767;
                  if (v < -32768) v = -32768;
               end
            end
            default: begin
               v = -32768 + int'((65536 * pos) / per);
            end
         endcase
         return v;
      endfunction

      function void note_word(shape_type shape, logic [FREQ_W-1:0] freq, logic blk);
         int unsigned per, pos;
         int          v;
         per = (period_len < 1) ? 1 : period_len;
         pos = (position >= per) ? per - 1 : position;
         v   = predict_sample(shape, pos, per);
         pos++;
         if (pos >= per) begin
            pos = 0;
            per = period_of(freq);
            wraps++;
         end
         position   = pos & 12'hFFF;
         period_len = per & 12'hFFF;
         pending_samples.push_back(v[15:0]);
         pending_block_ends.push_back(blk);
         shape_seen[shape]++;
         words_seen++;
      endfunction

      function void check_word(logic signed [15:0] smp, logic blk);
         logic signed [15:0] exp_smp;
         logic               exp_blk;
         if (pending_samples.size() == 0) begin
            $error("Result word with nothing pending: sample %0d block_end_out %0b", smp, blk);
            errors++;
            return;
         end
         exp_smp = pending_samples.pop_front();
         exp_blk = pending_block_ends.pop_front();
         samples_checked++;
         if (smp !== exp_smp) begin
            $error("sample: expected %0d, actual %0d", exp_smp, smp);
            errors++;
         end
         if (blk !== exp_blk) begin
            $error("block_end_out: expected %0b, actual %0b", exp_blk, blk);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [SHAPE_W-1:0]         req_wave_shape = '0;
   logic [FREQ_W-1:0]          req_new_frequency = '0;
   logic                       req_block_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_block_end_out;

   logic                       calm = 1'b0;
   int unsigned                stall_left = 0;
   tone_scoreboard             sb = new();

   multi_waveform_tone_generator_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_wave_shape    (req_wave_shape),
      .req_new_frequency (req_new_frequency),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample        (rsp_sample),
      .rsp_block_end_out (rsp_block_end_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_sample, rsp_block_end_out);
   end

   task automatic send_word(shape_type shape, logic [FREQ_W-1:0] freq, logic blk);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_wave_shape    <= shape;
      req_new_frequency <= freq;
      req_block_end     <= blk;
      do @(posedge clock); while (req_stall);
      sb.note_word(shape, freq, blk);
   endtask

   function automatic logic [FREQ_W-1:0] band_frequency(band_type band);
      case (band)
         BAND_HIGH:  return FREQ_W'($urandom_range(2000, FREQ_MAX));
         BAND_ABOVE: return FREQ_W'($urandom_range(FREQ_MAX + 1, (1 << FREQ_W) - 1));
         BAND_MID:   return FREQ_W'($urandom_range(441, 2000));
         BAND_NOISE: return FREQ_W'($urandom_range(441, (1 << FREQ_W) - 1));
         BAND_SLOW:  return FREQ_W'($urandom_range(100, 440));
         default:    return FREQ_W'($urandom_range(0, FREQ_MIN));
      endcase
   endfunction

   initial begin
      int unsigned        directed_freq [20];
      int unsigned        sent, seg_len, pick;
      band_type           band;
      logic [FREQ_W-1:0]  freq;
      bit                 deep_done;
      directed_freq = '{0, 1, 19, 20, 21, 440, 441, 2205, 8191, 8192,
                        12499, 12500, 12501, 16383, 4096, 2048, 1024, 100, 12345, 5461};
      deep_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 20; i++) begin
         send_word(shape_type'(i % 4), directed_freq[i][FREQ_W-1:0], i[0]);
      end

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         pick    = $urandom_range(0, 99);
         seg_len = $urandom_range(1, 40);
         if (pick < 45) band = BAND_HIGH;
         else if (pick < 65) band = BAND_ABOVE;
         else if (pick < 80) band = BAND_MID;
         else if (pick < 95) band = BAND_NOISE;
         else band = BAND_SLOW;
         if (!deep_done && sent >= DEEP_AT) begin
            band      = BAND_DEEP;
            seg_len   = 600;
            deep_done = 1'b1;
         end
         calm <= (sent + CALM_TAIL >= RANDOM_WORDS) || ($urandom_range(0, 3) == 0);
         freq = band_frequency(band);
         for (int unsigned i = 0; i < seg_len && sent < RANDOM_WORDS; i++) begin
            if (band == BAND_DEEP && sb.period_len > 2000) break;
            if (sent + CALM_TAIL >= RANDOM_WORDS) calm <= 1'b1;
            if (band == BAND_NOISE) freq = band_frequency(band);
            send_word(shape_type'($urandom_range(0, 3)), freq,
                      (i == seg_len - 1) || ($urandom_range(0, 7) == 0));
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (sb.pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);

      $display("Checked %0d samples from %0d words with %0d period wraps.",
               sb.samples_checked, sb.words_seen, sb.wraps);
      $display("Words per shape: sine %0d, square %0d, triangle %0d, sawtooth %0d.",
               sb.shape_seen[SHAPE_SINE], sb.shape_seen[SHAPE_SQUARE],
               sb.shape_seen[SHAPE_TRIANGLE], sb.shape_seen[SHAPE_SAWTOOTH]);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
